// ----- src/sha1_stream_hasher_unit_defines.svh -----
// Assertion macros shared by the SHA-1 stream hasher.
`ifndef SHA1_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA1_STREAM_HASHER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SHA1_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sha1_pkg.sv -----
// Types and constants of the SHA-1 stream hasher.
`timescale 1ns / 1ps
package sha1_pkg;

	typedef logic [31:0] word_t;
	typedef logic [4:0][31:0] chain_t;

	localparam word_t K_R0 = 32'h5A827999;
	localparam word_t K_R1 = 32'h6ED9EBA1;
	localparam word_t K_R2 = 32'h8F1BBCDC;
	localparam word_t K_R3 = 32'hCA62C1D6;

	localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [6:0] ROUND_LAST = 7'd80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_COMP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        wr_byte;
		logic [5:0]  pos;
		logic [7:0]  data;
		logic        wr_len;
		logic [63:0] len;
		logic        start;
		logic        init;
	} core_ctrl_t;

endpackage

// ----- src/sha1_compress.sv -----
// Block buffer, chaining words and the shared SHA-1 round unit.
`timescale 1ns / 1ps
module sha1_compress
	import sha1_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  core_ctrl_t ctrl,
	output logic       done,
	output chain_t     chain
);

	word_t      buf_q [16];
	chain_t     h_q;
	word_t      a_q, b_q, c_q, d_q, e_q;
	logic [6:0] round_q;
	logic       busy_q;
	logic       done_q;

	word_t      f;
	word_t      k;
	word_t      t;
	word_t      w_new;
	logic [1:0] lane;
	logic       rnd;

	assign rnd  = busy_q && (round_q != ROUND_LAST);
	assign lane = 2'd3 - ctrl.pos[1:0];

	always_comb begin
		if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K_R0;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K_R1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K_R2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K_R3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + buf_q[0];
		w_new = buf_q[13] ^ buf_q[8] ^ buf_q[2] ^ buf_q[0];
	end

	always_ff @(posedge clk) begin
		if (rnd) begin
			for (int i = 0; i < 15; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
			buf_q[15] <= {w_new[30:0], w_new[31]};
		end else begin
			if (ctrl.wr_byte) begin
				buf_q[ctrl.pos[5:2]][{lane, 3'b000} +: 8] <= ctrl.data;
			end
			if (ctrl.wr_len) begin
				buf_q[14] <= ctrl.len[63:32];
				buf_q[15] <= ctrl.len[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (rnd) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= H_INIT;
			round_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.init) begin
				h_q <= H_INIT;
			end
			if (ctrl.start) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end else if (rnd) begin
				round_q <= round_q + 7'd1;
			end else if (busy_q) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done  = done_q;
	assign chain = h_q;

endmodule

// ----- src/sha1_stream_hasher_unit.sv -----
// Top level of the SHA-1 stream hasher: byte intake, padding control and digest output.
//
// Message bytes arrive one per input beat, with tuser marking a byte that belongs to the
// message and tlast closing the message. A byte that completes a 64-byte block starts the
// compression, which runs one round per cycle in a single shared round unit: 80 rounds,
// the chaining add and the hand-back of control, and the input is held off until they
// are done. Closing a message writes the 0x80 marker and zero bytes one per cycle up to
// the length field, then the 64-bit bit length, then one compression; when fewer than nine
// bytes of the block are free a second block is padded and compressed first. The digest
// then leaves as five output beats, word 0 first, tlast on the fifth, and the hasher is
// ready for the next message. The input is not ready while a block is compressed, padded
// or the digest is being sent.
`timescale 1ns / 1ps
`include "sha1_stream_hasher_unit_defines.svh"
module sha1_stream_hasher_unit
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] byte_valid
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
	output logic        m_tlast    // last_word
);

	state_t      state_q, state_nx;
	logic [60:0] cnt_q;
	logic [5:0]  pos_q;
	logic        first_q;
	logic        eom_q;
	logic        len_q;
	logic [2:0]  idx_q;

	core_ctrl_t  ctrl;
	logic        core_done;
	chain_t      chain;
	logic        in_acc;
	logic        out_acc;
	logic        out_fin;

	sha1_compress u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.done   (core_done),
		.chain  (chain)
	);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (s_tuser && (cnt_q[5:0] == 6'd63)) begin
						state_nx = ST_COMP;
					end else if (s_tlast) begin
						state_nx = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (pos_q == 6'd55) begin
					state_nx = ST_LEN;
				end else if (pos_q == 6'd63) begin
					state_nx = ST_COMP;
				end
			end
			ST_LEN: begin
				state_nx = ST_COMP;
			end
			ST_COMP: begin
				if (core_done) begin
					if (len_q) begin
						state_nx = ST_OUT;
					end else if (eom_q) begin
						state_nx = ST_PAD;
					end else begin
						state_nx = ST_IDLE;
					end
				end
			end
			ST_OUT: begin
				if (out_fin) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		ctrl     = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready     = 1'b1;
				ctrl.wr_byte = s_tvalid && s_tuser;
				ctrl.pos     = cnt_q[5:0];
				ctrl.data    = s_tdata;
				ctrl.start   = s_tvalid && s_tuser && (cnt_q[5:0] == 6'd63);
			end
			ST_PAD: begin
				ctrl.wr_byte = 1'b1;
				ctrl.pos     = pos_q;
				ctrl.data    = first_q ? PAD_MARK : 8'h00;
				ctrl.start   = (pos_q == 6'd63);
			end
			ST_LEN: begin
				ctrl.wr_len = 1'b1;
				ctrl.len    = {cnt_q, 3'b000};
				ctrl.start  = 1'b1;
			end
			ST_OUT: begin
				m_tvalid  = 1'b1;
				ctrl.init = m_tready && (idx_q == 3'd4);
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign out_fin = out_acc && (idx_q == 3'd4);

	assign m_tdata = {5'd0, idx_q, chain[idx_q]};
	assign m_tlast = (idx_q == 3'd4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
			first_q <= 1'b0;
			eom_q   <= 1'b0;
			len_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (in_acc) begin
				eom_q   <= s_tlast;
				first_q <= 1'b1;
				len_q   <= 1'b0;
				pos_q   <= s_tuser ? (cnt_q[5:0] + 6'd1) : cnt_q[5:0];
				if (s_tuser) begin
					cnt_q <= cnt_q + 61'd1;
				end
			end
			if (state_q == ST_PAD) begin
				pos_q   <= pos_q + 6'd1;
				first_q <= 1'b0;
			end
			if (state_q == ST_LEN) begin
				len_q <= 1'b1;
			end
			if (out_acc) begin
				idx_q <= out_fin ? 3'd0 : (idx_q + 3'd1);
			end
			if (out_fin) begin
				cnt_q <= '0;
			end
		end
	end

	`SHA1_ASSERT_SAME(a_no_overlap, 1'b1, !(s_tready && m_tvalid), "input and output both active")
	`SHA1_ASSERT_NEXT(a_back_idle, out_fin, s_tready && (cnt_q == 61'd0), "no idle after digest")
	`SHA1_ASSERT_NEXT(a_close_busy, in_acc && s_tlast, !s_tready, "ready after message close")

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the SHA-1 stream hasher: directed and random messages against a predictor.
`timescale 1ns / 1ps
module tb
	import sha1_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 420;
	localparam int DRAIN_CYCLES = 200;

	localparam logic [159:0] NO_DIGEST = '0;
	localparam logic [159:0] EMPTY_DIGEST =
		160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
	localparam logic [159:0] ABC_DIGEST =
		160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

	typedef struct packed {
		logic [7:0]   data;
		logic         valid;
		logic         eom;
		logic         typed;
		logic [159:0] digest;
	} stim_row_t;

	typedef struct {
		word_t      digest;
		logic [2:0] index;
		logic       last;
	} digest_beat_t;

	localparam int N_DIRECTED = 19;
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
		'{8'h5a, 1'b0, 1'b0, 1'b0, NO_DIGEST},
		'{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
		'{8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST},
		'{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST},
		'{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'h63, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'h00, 1'b0, 1'b1, 1'b1, ABC_DIGEST},
		'{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},
		'{8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
		'{8'ha5, 1'b0, 1'b1, 1'b0, NO_DIGEST},
		'{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
		'{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},
		'{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
		'{8'h3c, 1'b0, 1'b0, 1'b0, NO_DIGEST}
	};

	int boundary_lens [10] = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 128};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	word_t        hash_state [5];
	word_t        msg_block [16];
	logic [60:0]  msg_len;
	word_t        digest_out [5];
	digest_beat_t pending_digest [$];
	int           failures = 0;
	int           idle_cycles = 0;
	int           stall_left = 0;
	bit           no_gaps = 1'b0;

	sha1_stream_hasher_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	function automatic void restart_hash();
		for (int i = 0; i < 5; i++) begin
			hash_state[i] = H_INIT[i];
		end
		msg_len = '0;
	endfunction

	function automatic void store_byte(input int pos, input logic [7:0] b);
		msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
	endfunction

	function automatic void compress_block();
		word_t w [80];
		word_t a, b, c, d, e, f, k, t, x;
		for (int i = 0; i < 16; i++) begin
			w[i] = msg_block[i];
		end
		for (int i = 16; i < 80; i++) begin
			x = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
			w[i] = {x[30:0], x[31]};
		end
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = K_R0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = K_R1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_R2;
			end else begin
				f = b ^ c ^ d;
				k = K_R3;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[i];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endfunction

	// Returns 1 when the beat closes the message; the digest is then in digest_out.
	function automatic logic hash_beat(input logic [7:0] data, input logic valid,
			input logic eom);
		logic [63:0] bit_len;
		int pos;
		if (valid) begin
			store_byte(int'(msg_len[5:0]), data);
			msg_len = msg_len + 61'd1;
			if (msg_len[5:0] == 6'd0) begin
				compress_block();
			end
		end
		if (!eom) begin
			return 1'b0;
		end
		bit_len = {msg_len, 3'b000};
		pos = int'(msg_len[5:0]);
		store_byte(pos, PAD_MARK);
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				store_byte(pos, 8'h00);
				pos++;
			end
			compress_block();
			pos = 0;
		end
		while (pos < 56) begin
			store_byte(pos, 8'h00);
			pos++;
		end
		msg_block[14] = bit_len[63:32];
		msg_block[15] = bit_len[31:0];
		compress_block();
		for (int i = 0; i < 5; i++) begin
			digest_out[i] = hash_state[i];
		end
		restart_hash();
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Called just after a falling edge; returns just after the falling edge that follows acceptance.
	task automatic put_beat(input logic [7:0] data, input logic valid, input logic eom,
			input logic typed, input logic [159:0] known_digest);
		int gap;
		digest_beat_t item;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= valid;
		s_tlast <= eom;
		do @(posedge clk); while (!s_tready);
		if (hash_beat(data, valid, eom)) begin
			for (int i = 0; i < 5; i++) begin
				item.digest = typed ? known_digest[159 - 32 * i -: 32] : digest_out[i];
				item.index = 3'(i);
				item.last = (i == 4);
				pending_digest.push_back(item);
			end
		end
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		digest_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_digest.size() == 0) begin
				$display("%0t: unexpected digest beat %h", $time, m_tdata);
				failures++;
			end else begin
				want = pending_digest.pop_front();
				if (m_tdata[31:0] !== want.digest) begin
					$display("%0t: digest_word expected %h, got %h", $time, want.digest,
						m_tdata[31:0]);
					failures++;
				end
				if (m_tdata[34:32] !== want.index) begin
					$display("%0t: word_index expected %0d, got %0d", $time, want.index,
						m_tdata[34:32]);
					failures++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: last_word expected %b, got %b", $time, want.last, m_tlast);
					failures++;
				end
				if (m_tdata[39:35] !== 5'd0) begin
					$display("%0t: tdata padding expected 00, got %h", $time, m_tdata[39:35]);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	initial begin
		int items;
		int len;
		int r;
		bit split_close;
		restart_hash();
		for (int i = 0; i < 16; i++) begin
			msg_block[i] = '0;
		end
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < N_DIRECTED; i++) begin
			put_beat(directed_rows[i].data, directed_rows[i].valid, directed_rows[i].eom,
				directed_rows[i].typed, directed_rows[i].digest);
		end
		items = 0;
		while (items < RANDOM_ITEMS) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 25) begin
				len = boundary_lens[$urandom_range(0, 9)];
			end else if (r < 75) begin
				len = $urandom_range(0, 20);
			end else begin
				len = $urandom_range(21, 80);
			end
			split_close = (len == 0) || ($urandom_range(0, 1) == 1);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 19) == 0) begin
					put_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NO_DIGEST);
					items++;
				end
				put_beat(8'($urandom_range(0, 255)), 1'b1, !split_close && (i == len - 1),
					1'b0, NO_DIGEST);
				items++;
			end
			if (split_close) begin
				put_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NO_DIGEST);
				items++;
			end
		end
		s_tvalid <= 1'b0;
		no_gaps = 1'b0;
		while (pending_digest.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
